// ===== rtl/core/jpe_pkg.sv =====
// jpe_pkg: shared types, constants and helpers of the jacobi polynomial evaluator
// no dependencies; imported by every module in rtl/core
package jpe_pkg;

	// fixed-point formats
	localparam int unsigned POLY_W  = 40;
	localparam int unsigned COEF_W  = 23;
	localparam int unsigned X_W     = 32;
	localparam int unsigned DEG_W   = 6;
	localparam int unsigned DIV_QB  = POLY_W + 1;
	localparam logic signed [63:0] ONE_Q16 = 64'sd65536;
	localparam logic signed [63:0] ONE_Q24 = 64'sd16777216;

	// configuration register indexes
	localparam logic REG_ALPHA = 1'b0;
	localparam logic REG_BETA  = 1'b1;

	typedef struct packed {
		logic [DEG_W-1:0]        degree;
		logic signed [X_W-1:0]   point_x;
	} req_t;

	typedef struct packed {
		logic signed [POLY_W-1:0] poly_value;
		logic                     overflow;
	} res_t;

	typedef struct packed {
		logic signed [63:0] val;
		logic               ov;
	} sat_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_MSTART,
		CS_MWAIT,
		CS_DSTART,
		CS_DWAIT
	} core_state_t;

	typedef enum logic [1:0] {
		ML_IDLE,
		ML_ACC,
		ML_SIGN
	} mul_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_CHECK,
		DV_RUN,
		DV_ROUND
	} div_state_t;

	// multiply program of one item: first term, then one pass per recurrence step
	typedef enum logic [3:0] {
		U_P1X,
		U_FA,
		U_FAB,
		U_AA,
		U_BB,
		U_FD,
		U_UV,
		U_UV2A,
		U_CXX,
		U_LP1,
		U_CSP2,
		U_KS,
		U_KSB
	} uop_t;

	function automatic uop_t uop_next(input uop_t op);
		uop_t r;
		case (op)
			U_P1X:   r = U_FA;
			U_FA:    r = U_FAB;
			U_FAB:   r = U_AA;
			U_AA:    r = U_BB;
			U_BB:    r = U_FD;
			U_FD:    r = U_UV;
			U_UV:    r = U_UV2A;
			U_UV2A:  r = U_CXX;
			U_CXX:   r = U_LP1;
			U_LP1:   r = U_CSP2;
			U_CSP2:  r = U_KS;
			U_KS:    r = U_KSB;
			default: r = U_FA;
		endcase
		return r;
	endfunction

	// round half away from zero, shift right by sh, saturate to a signed width
	function automatic sat_t sat_shift(input logic signed [127:0] v, input int unsigned sh,
			input int unsigned width);
		logic         neg;
		logic [127:0] m;
		logic [127:0] lim;
		sat_t         r;
		neg = v[127];
		m = neg ? 128'(-v) : 128'(v);
		m = m + (128'(1) << (sh - 1));
		m = m >> sh;
		lim = 128'(1) << (width - 1);
		if (!neg) lim = lim - 128'(1);
		r.ov = 1'b0;
		if (m > lim) begin
			m = lim;
			r.ov = 1'b1;
		end
		r.val = neg ? -signed'(m[63:0]) : signed'(m[63:0]);
		return r;
	endfunction

endpackage

// ===== rtl/core/jpe_mul.sv =====
// jpe_mul: shared 64x64 signed multiplier, one 32x32 partial product per cycle
// depends on jpe_pkg
module jpe_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [63:0]  op_a,
	input  logic signed [63:0]  op_b,
	output logic                done,
	output logic signed [127:0] prod
);
	import jpe_pkg::*;

	mul_state_t   state_q, state_d;
	logic [1:0]   cnt_q;
	logic [63:0]  am_q, bm_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [31:0]  a_half, b_half;
	logic [63:0]  pp;
	logic [127:0] pp_sh;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ML_IDLE: if (start) state_d = ML_ACC;
			ML_ACC:  if (cnt_q == 2'd3) state_d = ML_SIGN;
			ML_SIGN: state_d = ML_IDLE;
			default: state_d = ML_IDLE;
		endcase
	end

	// partial product select and weight
	always_comb begin
		a_half = cnt_q[1] ? am_q[63:32] : am_q[31:0];
		b_half = cnt_q[0] ? bm_q[63:32] : bm_q[31:0];
		pp = 64'(a_half) * 64'(b_half);
		case (cnt_q)
			2'd0:    pp_sh = 128'(pp);
			2'd3:    pp_sh = 128'(pp) << 64;
			default: pp_sh = 128'(pp) << 32;
		endcase
	end

	// outputs
	always_comb begin
		done = (state_q == ML_SIGN);
		prod = neg_q ? -signed'(acc_q) : signed'(acc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ML_IDLE;
			cnt_q <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ML_ACC) cnt_q <= cnt_q + 2'd1;
			else cnt_q <= 2'd0;
		end
	end

	// operand magnitudes and accumulator
	always_ff @(posedge clk) begin
		if (state_q == ML_IDLE && start) begin
			am_q <= op_a[63] ? 64'(-op_a) : 64'(op_a);
			bm_q <= op_b[63] ? 64'(-op_b) : 64'(op_b);
			neg_q <= op_a[63] ^ op_b[63];
			acc_q <= '0;
		end else if (state_q == ML_ACC) begin
			acc_q <= acc_q + pp_sh;
		end
	end

endmodule

// ===== rtl/core/jpe_div.sv =====
// jpe_div: restoring divider, one quotient bit per cycle, rounded and saturated to Q24
// depends on jpe_pkg
module jpe_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [127:0]        num,
	input  logic signed [63:0]         den,
	output logic                       done,
	output logic signed [jpe_pkg::POLY_W-1:0] quo,
	output logic                       ov
);
	import jpe_pkg::*;

	div_state_t      state_q, state_d;
	logic            neg_q, sat_q;
	logic [127:0]    nmag_q;
	logic [63:0]     dmag_q, rem_q;
	logic [DIV_QB-1:0] q_q;
	logic [5:0]      cnt_q;
	logic [86:0]     hi;
	logic            hi_big;
	logic [64:0]     rem2;
	logic            ge;
	logic            rnd;
	logic [DIV_QB:0] qr, lim, mag;

	assign hi = nmag_q[127:DIV_QB];
	assign hi_big = (hi >= 87'(dmag_q));
	assign rem2 = {rem_q, nmag_q[DIV_QB-1]};
	assign ge = (rem2 >= {1'b0, dmag_q});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			DV_IDLE:  if (start) state_d = DV_CHECK;
			DV_CHECK: state_d = hi_big ? DV_ROUND : DV_RUN;
			DV_RUN:   if (cnt_q == 6'(DIV_QB - 1)) state_d = DV_ROUND;
			DV_ROUND: state_d = DV_IDLE;
			default:  state_d = DV_IDLE;
		endcase
	end

	// rounding and saturation of the result
	always_comb begin
		rnd = ({rem_q, 1'b0} >= {1'b0, dmag_q});
		qr = {1'b0, q_q} + (DIV_QB + 1)'(rnd);
		lim = (DIV_QB + 1)'(1) << (POLY_W - 1);
		if (!neg_q) lim = lim - (DIV_QB + 1)'(1);
		ov = sat_q || (qr > lim);
		mag = ov ? lim : qr;
		quo = neg_q ? -signed'(mag[POLY_W-1:0]) : signed'(mag[POLY_W-1:0]);
		done = (state_q == DV_ROUND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// division datapath
	always_ff @(posedge clk) begin
		case (state_q)
			DV_IDLE: begin
				if (start) begin
					neg_q <= num[127] ^ den[63];
					nmag_q <= num[127] ? 128'(-num) : 128'(num);
					dmag_q <= den[63] ? 64'(-den) : 64'(den);
				end
			end
			DV_CHECK: begin
				sat_q <= hi_big;
				rem_q <= hi[63:0];
				q_q <= '0;
				cnt_q <= 6'd0;
			end
			DV_RUN: begin
				rem_q <= ge ? 64'(rem2 - {1'b0, dmag_q}) : rem2[63:0];
				q_q <= {q_q[DIV_QB-2:0], ge};
				nmag_q <= nmag_q << 1;
				cnt_q <= cnt_q + 6'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/jpe_core.sv =====
// jpe_core: sequencer of the recurrence, coefficient registers, shared multiplier and divider
// depends on jpe_pkg, jpe_mul, jpe_div
module jpe_core #(
	parameter int MAX_DEGREE = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  jpe_pkg::req_t                     req,
	input  logic signed [jpe_pkg::COEF_W-1:0] alpha,
	input  logic signed [jpe_pkg::COEF_W-1:0] beta,
	output logic                              busy,
	output logic                              done,
	output jpe_pkg::res_t                     result
);
	import jpe_pkg::*;

	localparam int KW = $clog2(MAX_DEGREE + 1);

	core_state_t        state_q, state_d;
	uop_t               op_q, op_d;
	logic [KW-1:0]      k_q, deg_q;
	logic signed [X_W-1:0]    x_q;
	logic signed [POLY_W-1:0] p1_q, p2_q;
	logic               ov_q;
	logic signed [63:0] t1_q, diff_q, cx_q, cc_q, cs_q, l_q, d_q;
	logic signed [127:0] num_q;
	logic               done_q;
	res_t               res_q;

	logic               accept, last_step, dzero;
	logic               mstart, mdone, dstart, ddone, dov;
	logic signed [127:0] mprod;
	logic signed [POLY_W-1:0] dval;
	logic signed [63:0] a64, b64, kq, big_a, big_b, big_f, s_ab, u_k, v_k, t_p1;
	logic signed [63:0] mop_a, mop_b;
	sat_t               sat16, sat30, sat23;

	assign accept = start && (state_q == CS_IDLE);
	assign last_step = (k_q == deg_q);
	assign dzero = (mprod[63:0] == 64'd0);

	// per-step terms
	always_comb begin
		a64 = 64'(alpha);
		b64 = 64'(beta);
		kq = signed'(64'(k_q) << 16);
		big_a = (kq <<< 1) + a64 + b64;
		big_b = big_a - (ONE_Q16 <<< 1);
		big_f = big_a - ONE_Q16;
		s_ab = kq + a64 + b64;
		u_k = kq + a64 - ONE_Q16;
		v_k = kq + b64 - ONE_Q16;
		t_p1 = ((a64 - b64) <<< 30) + mprod[63:0];
		sat16 = sat_shift(mprod, 16, 64);
		sat30 = sat_shift(mprod, 30, 64);
		sat23 = sat_shift(128'(t_p1), 23, POLY_W);
	end

	// multiplier operand select
	always_comb begin
		case (op_q)
			U_P1X:   begin mop_a = a64 + b64 + (ONE_Q16 <<< 1); mop_b = 64'(x_q); end
			U_FA:    begin mop_a = big_f; mop_b = big_a; end
			U_FAB:   begin mop_a = t1_q;  mop_b = big_b; end
			U_AA:    begin mop_a = a64;   mop_b = a64; end
			U_BB:    begin mop_a = b64;   mop_b = b64; end
			U_FD:    begin mop_a = big_f; mop_b = diff_q; end
			U_UV:    begin mop_a = u_k;   mop_b = v_k; end
			U_UV2A:  begin mop_a = t1_q;  mop_b = big_a <<< 1; end
			U_CXX:   begin mop_a = cx_q;  mop_b = 64'(x_q); end
			U_LP1:   begin mop_a = l_q;   mop_b = 64'(p1_q); end
			U_CSP2:  begin mop_a = cs_q;  mop_b = 64'(p2_q); end
			U_KS:    begin mop_a = signed'(64'(k_q) << 1); mop_b = s_ab; end
			U_KSB:   begin mop_a = t1_q;  mop_b = big_b; end
			default: begin mop_a = '0;    mop_b = '0; end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		op_d = op_q;
		case (state_q)
			CS_IDLE: begin
				if (start) begin
					state_d = CS_MSTART;
					op_d = U_P1X;
				end
			end
			CS_MSTART: state_d = CS_MWAIT;
			CS_MWAIT: begin
				if (mdone) begin
					op_d = uop_next(op_q);
					state_d = CS_MSTART;
					case (op_q)
						U_P1X: if (deg_q <= KW'(1)) state_d = CS_IDLE;
						U_KSB: begin
							if (!dzero) state_d = CS_DSTART;
							else if (last_step) state_d = CS_IDLE;
						end
						default: begin
						end
					endcase
				end
			end
			CS_DSTART: state_d = CS_DWAIT;
			CS_DWAIT: begin
				if (ddone) begin
					op_d = U_FA;
					state_d = last_step ? CS_IDLE : CS_MSTART;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	// unit strobes and status
	always_comb begin
		mstart = (state_q == CS_MSTART);
		dstart = (state_q == CS_DSTART);
		busy = (state_q != CS_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			op_q <= U_P1X;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
			done_q <= 1'b0;
			if (state_q == CS_MWAIT && mdone) begin
				if (op_q == U_P1X && deg_q <= KW'(1)) done_q <= 1'b1;
				if (op_q == U_KSB && dzero && last_step) done_q <= 1'b1;
			end
			if (state_q == CS_DWAIT && ddone && last_step) done_q <= 1'b1;
		end
	end

	// datapath registers and write-back
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= req.point_x;
			deg_q <= ({1'b0, req.degree} > 7'(MAX_DEGREE)) ? KW'(MAX_DEGREE) : KW'(req.degree);
			ov_q <= 1'b0;
			k_q <= KW'(2);
		end
		if (state_q == CS_MWAIT && mdone) begin
			case (op_q)
				U_P1X: begin
					p1_q <= sat23.val[POLY_W-1:0];
					p2_q <= ONE_Q24[POLY_W-1:0];
					if (deg_q == '0) begin
						res_q.poly_value <= ONE_Q24[POLY_W-1:0];
						res_q.overflow <= ov_q;
					end else begin
						ov_q <= ov_q | sat23.ov;
						res_q.poly_value <= sat23.val[POLY_W-1:0];
						res_q.overflow <= ov_q | sat23.ov;
					end
				end
				U_FA, U_AA, U_UV, U_KS: t1_q <= mprod[63:0];
				U_FAB: begin
					cx_q <= sat16.val;
					ov_q <= ov_q | sat16.ov;
				end
				U_BB: diff_q <= t1_q - mprod[63:0];
				U_FD: begin
					cc_q <= sat16.val;
					ov_q <= ov_q | sat16.ov;
				end
				U_UV2A: begin
					cs_q <= sat16.val;
					ov_q <= ov_q | sat16.ov;
				end
				U_CXX: begin
					l_q <= cc_q + sat30.val;
					ov_q <= ov_q | sat30.ov;
				end
				U_LP1: num_q <= mprod;
				U_CSP2: num_q <= num_q - mprod;
				U_KSB: begin
					d_q <= mprod[63:0];
					// zero divisor: step value is zero and flags overflow
					if (dzero) begin
						p2_q <= p1_q;
						p1_q <= '0;
						ov_q <= 1'b1;
						k_q <= k_q + KW'(1);
						res_q.poly_value <= '0;
						res_q.overflow <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == CS_DWAIT && ddone) begin
			p2_q <= p1_q;
			p1_q <= dval;
			ov_q <= ov_q | dov;
			k_q <= k_q + KW'(1);
			res_q.poly_value <= dval;
			res_q.overflow <= ov_q | dov;
		end
	end

	assign done = done_q;
	assign result = res_q;

	jpe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart),
		.op_a   (mop_a),
		.op_b   (mop_b),
		.done   (mdone),
		.prod   (mprod)
	);

	jpe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dstart),
		.num    (num_q),
		.den    (d_q),
		.done   (ddone),
		.quo    (dval),
		.ov     (dov)
	);

	// an accepted item keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not make the block busy");

	// a result strobe comes only after the sequencer went back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == CS_IDLE) && $past(state_q) != CS_IDLE)
		else $error("result strobe outside the end of an item");

	// recurrence steps stay within 2..degree
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != CS_IDLE && op_q != U_P1X) |-> (k_q >= KW'(2) && k_q <= deg_q))
		else $error("recurrence step index out of range");

endmodule

// ===== rtl/core/jacobi_polynomial_evaluator_top.sv =====
// jacobi_polynomial_evaluator_top: register port for alpha and beta, and the evaluator core
// each item runs one multiplier pass for the first term; each recurrence step for degree n >= 2
// adds twelve passes through the shared multiplier and a divide, skipped when the divisor is zero
// one item at a time: busy stays high until the result strobe; the receiver cannot stall
// asynchronous active-low reset clears alpha and beta to zero and returns the core to idle
// depends on jpe_pkg, jpe_core
module jacobi_polynomial_evaluator_top #(
	parameter int MAX_DEGREE = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  jpe_pkg::req_t req,
	output logic          done,
	output jpe_pkg::res_t result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import jpe_pkg::*;

	logic signed [COEF_W-1:0] alpha_q, beta_q;
	logic                     wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
			beta_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_ALPHA: alpha_q <= signed'(pwdata[COEF_W-1:0]);
				REG_BETA:  beta_q <= signed'(pwdata[COEF_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	// read back, sign extended
	always_comb begin
		case (paddr[2])
			REG_ALPHA: prdata = 32'(alpha_q);
			REG_BETA:  prdata = 32'(beta_q);
			default:   prdata = '0;
		endcase
	end

	jpe_core #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.alpha  (alpha_q),
		.beta   (beta_q),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

endmodule

// ===== sim/jacobi_polynomial_evaluator_top_test.sv =====
// jacobi_polynomial_evaluator_top_test: self-checking testbench of the jacobi evaluator top
// drives items and apb writes, predicts every result in fixed point; depends on jpe_pkg
module jacobi_polynomial_evaluator_top_test;
	import jpe_pkg::*;

	localparam int MAX_DEG = 32;
	localparam int QUIET_LIMIT = 20000;
	localparam logic [2:0] ADDR_ALPHA = 3'(4 * REG_ALPHA);
	localparam logic [2:0] ADDR_BETA  = 3'(4 * REG_BETA);

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        done;
	res_t        result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// current alpha and beta as the block holds them
	longint alpha_now = 0;
	longint beta_now = 0;

	req_t   pending_items[$];
	res_t   expected_values[$];
	int     mismatches = 0;
	int     quiet_cycles = 0;
	int     idle_left = 0;
	bit     burst_gaps = 1'b1;

	jacobi_polynomial_evaluator_top #(.MAX_DEGREE(MAX_DEG)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req), .done(done),
		.result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// saturate a magnitude with sign to a signed width
	function automatic longint clamp_mag(input logic [127:0] m, input logic neg,
			input int w, inout logic ov);
		logic [127:0] lim;
		lim = 128'd1 << (w - 1);
		if (!neg) lim = lim - 128'd1;
		if (m > lim) begin
			m = lim;
			ov = 1'b1;
		end
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	// round half away from zero, shift right, saturate
	function automatic longint round_narrow(input logic signed [127:0] v, input int sh,
			input int w, inout logic ov);
		logic         neg;
		logic [127:0] m;
		neg = v[127];
		m = neg ? -v : v;
		m = (m + (128'd1 << (sh - 1))) >> sh;
		return clamp_mag(m, neg, w, ov);
	endfunction

	// rounded quotient, saturated to the value width
	function automatic longint rounded_quotient(input logic signed [127:0] num,
			input longint den, inout logic ov);
		logic [127:0] n;
		logic [127:0] d;
		logic [127:0] q;
		logic [127:0] r;
		logic         neg;
		neg = num[127] != (den < 0);
		n = num[127] ? -num : num;
		d = den < 0 ? 128'(-den) : 128'(den);
		q = n / d;
		r = n % d;
		if (r >= d - r) q = q + 128'd1;
		return clamp_mag(q, neg, POLY_W, ov);
	endfunction

	// three-term recurrence in the block's fixed-point formats
	function automatic res_t jacobi_value(input req_t it, input longint a, input longint b);
		res_t               r;
		logic               ov;
		int                 n;
		longint             x, t, p1, p2, pk, kq, A, Bm, F, D, cx, cc, cs, L;
		logic signed [127:0] w1, w2, num;
		ov = 1'b0;
		n = it.degree;
		if (n > MAX_DEG) n = MAX_DEG;
		x = longint'($signed(it.point_x));
		if (n == 0) begin
			p1 = 64'sd16777216;
		end else begin
			t = (a - b) * (64'sd1 <<< 30) + (a + b + 2 * 65536) * x;
			w1 = t;
			p1 = round_narrow(w1, 23, POLY_W, ov);
			p2 = 64'sd16777216;
			for (int k = 2; k <= n; k++) begin
				kq = longint'(k) * 65536;
				A = 2 * kq + a + b;
				Bm = A - 2 * 65536;
				F = A - 65536;
				D = (2 * longint'(k) * (kq + a + b)) * Bm;
				w1 = F * A;
				w2 = Bm;
				cx = round_narrow(w1 * w2, 16, 64, ov);
				w1 = F;
				w2 = a * a - b * b;
				cc = round_narrow(w1 * w2, 16, 64, ov);
				w1 = (kq + a - 65536) * (kq + b - 65536);
				w2 = 2 * A;
				cs = round_narrow(w1 * w2, 16, 64, ov);
				w1 = cx;
				w2 = x;
				L = cc + round_narrow(w1 * w2, 30, 64, ov);
				w1 = L;
				w2 = p1;
				num = w1 * w2;
				w1 = cs;
				w2 = p2;
				num = num - w1 * w2;
				if (D == 0) begin
					pk = 0;
					ov = 1'b1;
				end else begin
					pk = rounded_quotient(num, D, ov);
				end
				p2 = p1;
				p1 = pk;
			end
		end
		r.poly_value = p1[POLY_W-1:0];
		r.overflow = ov;
		return r;
	endfunction

	// driver: present the head item until the block takes it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				void'(pending_items.pop_front());
				if (burst_gaps && $urandom_range(0, 5) == 0) idle_left = $urandom_range(1, 19);
			end
			if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (pending_items.size() > 0) begin
				start <= 1'b1;
				req <= pending_items[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: predict on accept, check on done, watch for a hang
	always @(posedge clk) begin
		res_t want;
		bit   active;
		if (arst_n) begin
			active = (start && !busy) || psel || done;
			quiet_cycles <= active ? 0 : quiet_cycles + 1;
			if (start && !busy) begin
				expected_values.push_back(jacobi_value(req, alpha_now, beta_now));
			end
			if (done) begin
				if (expected_values.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %h", result);
				end else begin
					want = expected_values.pop_front();
					if (result.poly_value !== want.poly_value
							|| result.overflow !== want.overflow) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: value %h ov %b, expected value %h ov %b",
								result.poly_value, result.overflow,
								want.poly_value, want.overflow);
					end
				end
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic reg_write(input logic [2:0] addr, input longint value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value[31:0];
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_ALPHA) alpha_now = longint'($signed(value[COEF_W-1:0]));
		else beta_now = longint'($signed(value[COEF_W-1:0]));
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (pending_items.size() > 0 || expected_values.size() > 0
			|| start || busy);
	endtask

	// mostly small degrees keep the run short; a few reach the clamp
	task automatic queue_random(input int count);
		req_t it;
		int   pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) it.degree = 6'($urandom_range(0, 8));
			else if (pick < 9) it.degree = 6'($urandom_range(0, 32));
			else it.degree = 6'($urandom_range(33, 63));
			it.point_x = $urandom;
			pending_items.push_back(it);
		end
	endtask

	task automatic queue_item(input int deg, input logic [31:0] x);
		req_t it;
		it.degree = 6'(deg);
		it.point_x = x;
		pending_items.push_back(it);
	endtask

	task automatic run_phase(input longint a, input longint b, input int count);
		reg_write(ADDR_ALPHA, a);
		reg_write(ADDR_BETA, b);
		queue_random(count);
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: degree extremes, x extremes, clamp above the maximum degree
		queue_item(0, 32'h8000_0000);
		queue_item(1, 32'h8000_0000);
		queue_item(1, 32'h7fff_ffff);
		queue_item(2, 32'h4000_0000);
		queue_item(2, 32'hc000_0000);
		queue_item(3, 32'h0000_0000);
		queue_item(32, 32'h7fff_ffff);
		queue_item(33, 32'h2000_0000);
		queue_item(63, 32'h8000_0000);
		queue_item(5, 32'h0000_0001);
		queue_item(4, 32'hffff_ffff);
		wait_drained();
		reg_write(ADDR_ALPHA, 4194303);
		reg_write(ADDR_BETA, -65535);
		queue_item(32, 32'h7fff_ffff);
		queue_item(32, 32'h8000_0000);
		queue_item(1, 32'h7fff_ffff);
		queue_item(7, 32'h3000_0000);
		wait_drained();
		// zero divisor: alpha = beta = -1
		reg_write(ADDR_ALPHA, -65536);
		reg_write(ADDR_BETA, -65536);
		queue_item(2, 32'h1000_0000);
		queue_item(6, 32'hf000_0000);
		queue_item(0, 32'h1234_5678);
		queue_item(1, 32'h4000_0000);
		wait_drained();
		// random phases across in-range and out-of-range parameters
		run_phase(0, 0, 75);
		run_phase(-65535, 4194303, 60);
		run_phase(-4194304, -4194304, 50);
		run_phase(-65536, -65536, 40);
		run_phase(-65535, -65535, 60);
		run_phase(longint'($urandom_range(0, 1048576)) - 65535,
			longint'($urandom_range(0, 1048576)) - 65535, 75);
		run_phase(longint'($urandom_range(0, 400000)), longint'($urandom_range(0, 400000)), 75);
		burst_gaps = 1'b0;
		run_phase(32768, 98304, 75);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_values.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/jpe_pkg.sv
rtl/core/jpe_mul.sv
rtl/core/jpe_div.sv
rtl/core/jpe_core.sv
rtl/core/jacobi_polynomial_evaluator_top.sv
sim/jacobi_polynomial_evaluator_top_test.sv
